### rtl/nss_pkg.sv
// Shared types and constants for the nearest symbol selector.
package nss_pkg;

	localparam int SYM_W = 16;
	localparam int VAL_W = 32;
	localparam int OFF_W = 12;
	localparam int CFG_W = 32;

	// Best offset of an empty class.
	localparam logic [OFF_W:0] NoCand = 13'h1000;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_QUERY   = 2'd0,
		REG_CUR_ID  = 2'd1,
		REG_CUR_SET = 2'd2
	} reg_idx_t;

	// Candidate classes: global/local, in current module or another one.
	typedef enum logic [1:0] {
		CLS_GC = 2'd0,
		CLS_LC = 2'd1,
		CLS_GO = 2'd2,
		CLS_LO = 2'd3
	} cls_t;

	typedef struct packed {
		logic             is_module;
		logic [SYM_W-1:0] entry_id;
		logic [VAL_W-1:0] entry_value;
		logic             is_global;
		logic             is_suppressed;
		logic             last_entry;
	} entry_t;

	typedef struct packed {
		logic             found;
		logic [SYM_W-1:0] symbol_id;
		logic             module_valid;
		logic [SYM_W-1:0] module_id;
		logic [OFF_W-1:0] offset;
	} result_t;

	typedef struct packed {
		logic [VAL_W-1:0] query;
		logic [SYM_W-1:0] cur_id;
		logic             cur_set;
	} cfg_t;

	// Classified entry passed from front to back.
	typedef struct packed {
		logic             cand;
		cls_t             cls;
		logic [OFF_W-1:0] diff;
		logic [SYM_W-1:0] id;
		logic             mod_valid;
		logic [SYM_W-1:0] mod_id;
		logic             last;
	} item_t;

endpackage

### rtl/nss_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
interface nss_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/nearest_symbol_selector_top.sv
// Top level of the nearest symbol selector: config registers, front, queue, back.
//
// Usage: program query_value, current_module_id and current_module_set through
// the write port (wr_en, wr_index, wr_data) while no scan is in flight, then
// stream symbol-table entries on the entry channel, one beat per entry. The
// beat with last_entry set closes the scan; one beat then leaves on the result
// channel with the best symbol, its module and its offset below the query.
// Entries that are not last give no result beat.
// Throughput: one entry per cycle while the queue is not full; the front
// classifies each beat in the cycle it is accepted and the back does one
// running-minimum update per cycle. The last entry is registered in the
// two-entry queue and then in the result register, which drives the result beat.
// Receiver stall: the result register holds its beat; entries keep flowing until
// a further last entry reaches the back end and the queue fills, then the entry
// channel deasserts ready.
// Reset: arst_n clears the registers, the scan state and the queue; the result
// channel is idle and the block is ready for entries at once.
module nearest_symbol_selector_top #(
	parameter int ENTRY_ID_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [1:0]                wr_index,
	input  logic [nss_pkg::CFG_W-1:0] wr_data,
	nss_stream_if.sink                entry,
	nss_stream_if.source              result
);

	nss_pkg::cfg_t  cfg_q;
	logic           full;
	logic           push;
	nss_pkg::item_t push_item;
	logic           pop;
	logic           not_empty;
	nss_pkg::item_t head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (nss_pkg::reg_idx_t'(wr_index))
				nss_pkg::REG_QUERY:   cfg_q.query   <= wr_data;
				nss_pkg::REG_CUR_ID:  cfg_q.cur_id  <= wr_data[nss_pkg::SYM_W-1:0];
				nss_pkg::REG_CUR_SET: cfg_q.cur_set <= wr_data[0];
				default:              cfg_q         <= cfg_q;
			endcase
		end
	end

	nss_front #(.ID_BITS(ENTRY_ID_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.entry     (entry),
		.full      (full),
		.push      (push),
		.push_item (push_item)
	);

	nss_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	nss_back #(.ID_BITS(ENTRY_ID_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.result    (result)
	);

endmodule

### rtl/nss_front.sv
// Front end: accepts entry beats, tracks the open module and classifies symbols.
module nss_front #(
	parameter int ID_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nss_pkg::cfg_t       cfg,
	nss_stream_if.sink          entry,
	input  logic                full,
	output logic                push,
	output nss_pkg::item_t      push_item
);

	localparam int IdW = (ID_BITS < nss_pkg::SYM_W) ? ID_BITS : nss_pkg::SYM_W;
	localparam logic [nss_pkg::SYM_W-1:0] IdMask =
		nss_pkg::SYM_W'((64'd1 << IdW) - 64'd1);

	logic                      mod_valid_q;
	logic [nss_pkg::SYM_W-1:0] mod_id_q;
	logic                      in_cur_q;

	logic [nss_pkg::SYM_W-1:0] id;
	logic [nss_pkg::VAL_W-1:0] diff;
	logic                      hit_cur;

	assign entry.ready = !full;
	assign push        = entry.valid && !full;

	// Classify the incoming beat
	always_comb begin
		id      = entry.data.entry_id & IdMask;
		diff    = cfg.query - entry.data.entry_value;
		hit_cur = cfg.cur_set && (id == cfg.cur_id);

		push_item.cand = !entry.data.is_module && !entry.data.is_suppressed &&
			(diff[nss_pkg::VAL_W-1:nss_pkg::OFF_W] == '0);
		case ({entry.data.is_global, in_cur_q})
			2'b11:   push_item.cls = nss_pkg::CLS_GC;
			2'b01:   push_item.cls = nss_pkg::CLS_LC;
			2'b10:   push_item.cls = nss_pkg::CLS_GO;
			default: push_item.cls = nss_pkg::CLS_LO;
		endcase
		push_item.diff      = diff[nss_pkg::OFF_W-1:0];
		push_item.id        = id;
		push_item.mod_valid = mod_valid_q;
		push_item.mod_id    = mod_id_q;
		push_item.last      = entry.data.last_entry;
	end

	// Open module tracking, cleared at the end of each scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_valid_q <= 1'b0;
			mod_id_q    <= '0;
			in_cur_q    <= 1'b0;
		end else if (push) begin
			if (entry.data.last_entry) begin
				mod_valid_q <= 1'b0;
				mod_id_q    <= '0;
				in_cur_q    <= 1'b0;
			end else if (entry.data.is_module) begin
				mod_valid_q <= 1'b1;
				mod_id_q    <= id;
				in_cur_q    <= hit_cur;
			end
		end
	end

endmodule

### rtl/nss_fifo.sv
// Two-entry queue between front and back ends.
module nss_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nss_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output nss_pkg::item_t head
);

	nss_pkg::item_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");
`endif

endmodule

### rtl/nss_back.sv
// Back end: per-class running minimum, final selection and result register.
module nss_back #(
	parameter int ID_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  nss_pkg::cfg_t  cfg,
	input  logic           not_empty,
	input  nss_pkg::item_t head,
	output logic           pop,
	nss_stream_if.source   result
);

	localparam int IdW = (ID_BITS < nss_pkg::SYM_W) ? ID_BITS : nss_pkg::SYM_W;
	localparam int OffW = nss_pkg::OFF_W;

	logic [OffW:0]    off_q [4];
	logic [IdW-1:0]   sym_q [4];
	logic             om_v_q [2];
	logic [IdW-1:0]   om_id_q [2];
	logic             exact_q;
	logic [IdW-1:0]   xsym_q;

	logic [OffW:0]    nxt_off [4];
	logic [IdW-1:0]   nxt_sym [4];
	logic             nxt_om_v [2];
	logic [IdW-1:0]   nxt_om_id [2];
	logic             nxt_exact;
	logic [IdW-1:0]   nxt_xsym;

	logic             out_valid_q;
	nss_pkg::result_t res_q;
	nss_pkg::result_t res;
	logic             out_free;
	logic             finish;
	logic [OffW:0]    g, l, o;
	logic [nss_pkg::SYM_W-1:0] cid;

	assign out_free     = !out_valid_q || result.ready;
	assign pop          = not_empty && (!head.last || out_free);
	assign finish       = pop && head.last;
	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	// Running minimum update for the popped beat
	always_comb begin
		nxt_off   = off_q;
		nxt_sym   = sym_q;
		nxt_om_v  = om_v_q;
		nxt_om_id = om_id_q;
		nxt_exact = exact_q;
		nxt_xsym  = xsym_q;
		if (pop && head.cand && !exact_q) begin
			if (head.cls == nss_pkg::CLS_GC && head.diff == '0) begin
				nxt_exact = 1'b1;
				nxt_xsym  = head.id[IdW-1:0];
			end else if ({1'b0, head.diff} < off_q[head.cls]) begin
				nxt_off[head.cls] = {1'b0, head.diff};
				nxt_sym[head.cls] = head.id[IdW-1:0];
				if (head.cls == nss_pkg::CLS_GO) begin
					nxt_om_v[0]  = head.mod_valid;
					nxt_om_id[0] = head.mod_id[IdW-1:0];
				end
				if (head.cls == nss_pkg::CLS_LO) begin
					nxt_om_v[1]  = head.mod_valid;
					nxt_om_id[1] = head.mod_id[IdW-1:0];
				end
			end
		end
	end

	// Final choice over the updated classes
	always_comb begin
		g   = nxt_off[nss_pkg::CLS_GC];
		l   = nxt_off[nss_pkg::CLS_LC];
		o   = nxt_off[nss_pkg::CLS_GO];
		cid = cfg.cur_set ? cfg.cur_id : '0;

		res.found        = 1'b0;
		res.symbol_id    = '0;
		res.module_valid = cfg.cur_set;
		res.module_id    = cid;
		res.offset       = '0;

		if (nxt_exact) begin
			res.found     = 1'b1;
			res.symbol_id = nss_pkg::SYM_W'(nxt_xsym);
		end else if (l == '0) begin
			res.found     = 1'b1;
			res.symbol_id = nss_pkg::SYM_W'(nxt_sym[nss_pkg::CLS_LC]);
		end else if (o == '0) begin
			res.found        = 1'b1;
			res.symbol_id    = nss_pkg::SYM_W'(nxt_sym[nss_pkg::CLS_GO]);
			res.module_valid = nxt_om_v[0];
			res.module_id    = nxt_om_v[0] ? nss_pkg::SYM_W'(nxt_om_id[0]) : '0;
		end else if (nxt_off[nss_pkg::CLS_LO] == '0) begin
			res.found        = 1'b1;
			res.symbol_id    = nss_pkg::SYM_W'(nxt_sym[nss_pkg::CLS_LO]);
			res.module_valid = nxt_om_v[1];
			res.module_id    = nxt_om_v[1] ? nss_pkg::SYM_W'(nxt_om_id[1]) : '0;
		end else if (g <= l && g <= o) begin
			if (g != nss_pkg::NoCand) begin
				res.found     = 1'b1;
				res.symbol_id = nss_pkg::SYM_W'(nxt_sym[nss_pkg::CLS_GC]);
				res.offset    = g[OffW-1:0];
			end
		end else if (l <= o) begin
			res.found     = 1'b1;
			res.symbol_id = nss_pkg::SYM_W'(nxt_sym[nss_pkg::CLS_LC]);
			res.offset    = l[OffW-1:0];
		end else begin
			res.found        = 1'b1;
			res.symbol_id    = nss_pkg::SYM_W'(nxt_sym[nss_pkg::CLS_GO]);
			res.module_valid = nxt_om_v[0];
			res.module_id    = nxt_om_v[0] ? nss_pkg::SYM_W'(nxt_om_id[0]) : '0;
			res.offset       = o[OffW-1:0];
		end
	end

	// Scan state, cleared after the last beat of a scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				off_q[i] <= nss_pkg::NoCand;
				sym_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				om_v_q[i]  <= 1'b0;
				om_id_q[i] <= '0;
			end
			exact_q <= 1'b0;
			xsym_q  <= '0;
		end else if (finish) begin
			for (int i = 0; i < 4; i++) begin
				off_q[i] <= nss_pkg::NoCand;
				sym_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				om_v_q[i]  <= 1'b0;
				om_id_q[i] <= '0;
			end
			exact_q <= 1'b0;
			xsym_q  <= '0;
		end else begin
			off_q   <= nxt_off;
			sym_q   <= nxt_sym;
			om_v_q  <= nxt_om_v;
			om_id_q <= nxt_om_id;
			exact_q <= nxt_exact;
			xsym_q  <= nxt_xsym;
		end
	end

	// Result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_q <= res;
		end
	end

`ifndef ASSERT_OFF
	a_clear_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> !exact_q && off_q[0] == nss_pkg::NoCand)
		else $error("scan state not cleared after last beat");
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		off_q[1] <= nss_pkg::NoCand && off_q[2] <= nss_pkg::NoCand)
		else $error("class offset out of range");
	a_no_pop_on_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> out_free)
		else $error("result overwritten before taken");
	a_gc_never_zero: assert property (@(posedge clk) disable iff (!arst_n)
		off_q[0] != '0)
		else $error("global exact hit stored as a class minimum");
`endif

endmodule
